[hdl/lorenz_system_integrator_top_assert.svh]
// Assertion macros used by the checker of the Lorenz integrator.
`ifndef LORENZ_SYSTEM_INTEGRATOR_TOP_ASSERT_SVH
`define LORENZ_SYSTEM_INTEGRATOR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, switched off while rst_n is low.
`define LSI_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lsi assertion failed");

// Next-cycle implication, sampled on clk, switched off while rst_n is low.
`define LSI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lsi assertion failed");

`endif

[hdl/lsi_pkg.sv]
// Shared types, codes and the micro-program of the Lorenz integrator.
package lsi_pkg;

    typedef logic [1:0] op_t;
    localparam op_t OP_ADD  = 2'd0;
    localparam op_t OP_SUB  = 2'd1;
    localparam op_t OP_ADDS = 2'd2;   // add, second operand halved in the first two stages
    localparam op_t OP_MUL  = 2'd3;

    typedef logic [4:0] src_t;
    localparam src_t SRC_PX   = 5'd0;
    localparam src_t SRC_PY   = 5'd1;
    localparam src_t SRC_PZ   = 5'd2;
    localparam src_t SRC_QX   = 5'd3;
    localparam src_t SRC_QY   = 5'd4;
    localparam src_t SRC_QZ   = 5'd5;
    localparam src_t SRC_KX   = 5'd6;
    localparam src_t SRC_KY   = 5'd7;
    localparam src_t SRC_KZ   = 5'd8;
    localparam src_t SRC_RX   = 5'd9;
    localparam src_t SRC_RY   = 5'd10;
    localparam src_t SRC_RZ   = 5'd11;
    localparam src_t SRC_T0   = 5'd12;
    localparam src_t SRC_T1   = 5'd13;
    localparam src_t SRC_SIG  = 5'd14;
    localparam src_t SRC_RHO  = 5'd15;
    localparam src_t SRC_BETA = 5'd16;
    localparam src_t SRC_DT   = 5'd17;
    localparam src_t SRC_CS   = 5'd18;   // one sixth or one third, by stage

    typedef struct packed {
        op_t  op;
        src_t a;
        src_t b;
        src_t d;
    } uop_t;

    typedef logic [4:0] pc_t;
    localparam pc_t PC_DERIV_END = 5'd10;
    localparam pc_t PC_EUL       = 5'd11;
    localparam pc_t PC_EUL_END   = 5'd13;
    localparam pc_t PC_RK        = 5'd14;
    localparam pc_t PC_RK_END    = 5'd22;
    localparam pc_t PC_FIN       = 5'd23;
    localparam pc_t PC_FIN_END   = 5'd25;

    typedef logic [2:0] reg_idx_t;
    localparam reg_idx_t REG_SIGMA = 3'd0;
    localparam reg_idx_t REG_RHO   = 3'd1;
    localparam reg_idx_t REG_BETA  = 3'd2;
    localparam reg_idx_t REG_DT    = 3'd3;
    localparam reg_idx_t REG_MODE  = 3'd4;

    function automatic uop_t uop_rom(input pc_t pc);
        uop_t u;
        case (pc)
            // derivative of the working point q, scaled by dt
            5'd0:  u = '{OP_SUB,  SRC_QY,   SRC_QX,  SRC_T0};
            5'd1:  u = '{OP_MUL,  SRC_SIG,  SRC_T0,  SRC_T0};
            5'd2:  u = '{OP_MUL,  SRC_T0,   SRC_DT,  SRC_KX};
            5'd3:  u = '{OP_SUB,  SRC_RHO,  SRC_QZ,  SRC_T0};
            5'd4:  u = '{OP_MUL,  SRC_QX,   SRC_T0,  SRC_T0};
            5'd5:  u = '{OP_SUB,  SRC_T0,   SRC_QY,  SRC_T0};
            5'd6:  u = '{OP_MUL,  SRC_T0,   SRC_DT,  SRC_KY};
            5'd7:  u = '{OP_MUL,  SRC_QX,   SRC_QY,  SRC_T0};
            5'd8:  u = '{OP_MUL,  SRC_BETA, SRC_QZ,  SRC_T1};
            5'd9:  u = '{OP_SUB,  SRC_T0,   SRC_T1,  SRC_T0};
            5'd10: u = '{OP_MUL,  SRC_T0,   SRC_DT,  SRC_KZ};
            // Euler update
            5'd11: u = '{OP_ADD,  SRC_PX,   SRC_KX,  SRC_PX};
            5'd12: u = '{OP_ADD,  SRC_PY,   SRC_KY,  SRC_PY};
            5'd13: u = '{OP_ADD,  SRC_PZ,   SRC_KZ,  SRC_PZ};
            // Runge-Kutta stage update
            5'd14: u = '{OP_MUL,  SRC_KX,   SRC_CS,  SRC_T0};
            5'd15: u = '{OP_ADD,  SRC_RX,   SRC_T0,  SRC_RX};
            5'd16: u = '{OP_ADDS, SRC_PX,   SRC_KX,  SRC_QX};
            5'd17: u = '{OP_MUL,  SRC_KY,   SRC_CS,  SRC_T0};
            5'd18: u = '{OP_ADD,  SRC_RY,   SRC_T0,  SRC_RY};
            5'd19: u = '{OP_ADDS, SRC_PY,   SRC_KY,  SRC_QY};
            5'd20: u = '{OP_MUL,  SRC_KZ,   SRC_CS,  SRC_T0};
            5'd21: u = '{OP_ADD,  SRC_RZ,   SRC_T0,  SRC_RZ};
            5'd22: u = '{OP_ADDS, SRC_PZ,   SRC_KZ,  SRC_QZ};
            // Runge-Kutta final sum
            5'd23: u = '{OP_ADD,  SRC_PX,   SRC_RX,  SRC_PX};
            5'd24: u = '{OP_ADD,  SRC_PY,   SRC_RY,  SRC_PY};
            5'd25: u = '{OP_ADD,  SRC_PZ,   SRC_RZ,  SRC_PZ};
            default: u = '{OP_ADD, SRC_T0,  SRC_T1,  SRC_T1};
        endcase
        return u;
    endfunction

endpackage

[hdl/lorenz_system_integrator_top.sv]
// Top level of the Lorenz system integrator: sequencer, registers and ports.
// The block holds a point (x, y, z) of the Lorenz system in signed fixed point.
// A request on the s_axis channel carries a command in tuser: advance the point
// by one time step, or load it from tdata. Every request yields exactly one
// result on the m_axis channel carrying the new point and a saturation flag.
// A load passes the DONE state before its result is registered for m_axis. A step
// runs a micro-program through one bit-serial multiplier, one product bit per
// cycle, on operands as wide as the largest of 32, STATE_WIDTH and FRAC_BITS.
// Forward Euler uses 7 products and 7 adds; Runge-Kutta uses 40 products and
// 43 adds. The products share the multiplier; requests are handled one at a
// time. A new request is taken as soon as the sequencer is idle, even while
// the previous result still waits in the output register; if the receiver
// stalls, the finished point waits in the sequencer until the output register
// frees. Reset puts the point at (0.1, 0, 0), the coefficients at sigma 10,
// rho 28, beta 8/3, dt 0.01 and the mode at Euler. The user must write
// registers over the APB port only while no request is in flight; the block
// itself does not enforce it.
module lorenz_system_integrator_top #(
    parameter int STATE_WIDTH = 32,
    parameter int FRAC_BITS   = 22
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,   // load_x [31:0], load_y [63:32], load_z [95:64]
    input  logic [0:0]   s_axis_tuser,   // cmd [0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata,   // out_x [31:0], out_y [63:32], out_z [95:64]
    output logic [0:0]   m_axis_tuser,   // saturated [0]
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int SW  = STATE_WIDTH;
    localparam int OPW0 = (SW > 32) ? SW : 32;
    // Operands must also hold the one-third constant, which needs FRAC_BITS bits.
    localparam int OPW = (OPW0 > FRAC_BITS) ? OPW0 : FRAC_BITS;

    localparam logic signed [OPW:0] ST_MAX =
        $signed({{(OPW-SW+2){1'b0}}, {(SW-1){1'b1}}});
    localparam logic signed [OPW:0] ST_MIN =
        $signed({{(OPW-SW+2){1'b1}}, {(SW-1){1'b0}}});

    localparam logic signed [OPW-1:0] C6 = OPW'(((64'd1 << FRAC_BITS) + 64'd3) / 64'd6);
    localparam logic signed [OPW-1:0] C3 = OPW'(((64'd1 << FRAC_BITS) + 64'd1) / 64'd3);

    localparam logic [31:0] SIGMA_RST = 32'(64'd10 << FRAC_BITS);
    localparam logic [31:0] RHO_RST   = 32'(64'd28 << FRAC_BITS);
    localparam logic [31:0] BETA_RST  = 32'(((64'd8 << FRAC_BITS) + 64'd1) / 64'd3);
    localparam logic [30:0] DT_RST    = 31'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic [SW-1:0] PX_RST  = SW'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);

    // Sequencer states.
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EXEC  = 2'd1;
    localparam logic [1:0] ST_MWAIT = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]            state_reg, state_next;
    lsi_pkg::pc_t          pc_reg, pc_next;
    logic [1:0]            stage_reg, stage_next;
    logic                  clip_reg, clip_next;

    logic signed [31:0]    sigma_reg, sigma_next;
    logic signed [31:0]    rho_reg, rho_next;
    logic signed [31:0]    beta_reg, beta_next;
    logic [30:0]           dt_reg, dt_next;
    logic                  mode_reg, mode_next;

    logic signed [SW-1:0]  px_reg, px_next, py_reg, py_next, pz_reg, pz_next;
    logic signed [SW-1:0]  qx_reg, qx_next, qy_reg, qy_next, qz_reg, qz_next;
    logic signed [SW-1:0]  kx_reg, kx_next, ky_reg, ky_next, kz_reg, kz_next;
    logic signed [SW-1:0]  rx_reg, rx_next, ry_reg, ry_next, rz_reg, rz_next;
    logic signed [SW-1:0]  t0_reg, t0_next, t1_reg, t1_next;

    logic                  out_valid_reg, out_valid_next;
    logic [31:0]           ox_reg, ox_next, oy_reg, oy_next, oz_reg, oz_next;
    logic                  osat_reg, osat_next;

    lsi_pkg::uop_t         u;
    logic signed [OPW-1:0] opa, opb;
    logic signed [OPW:0]   alu_a, alu_b, alu_sum;
    logic [SW:0]           alu_res, ld_x, ld_y, ld_z;
    logic                  mul_start, mul_done, mul_clip;
    logic signed [SW-1:0]  mul_prod;
    logic                  wr_en, adv, cfg_wr;
    logic signed [SW-1:0]  wr_val;
    logic                  wr_clip;

    // Returns the saturation flag above the value clipped to the state range.
    function automatic logic [SW:0] sat_sw(input logic signed [OPW:0] v);
        logic [SW:0] r;
        if (v > ST_MAX)
            r = {1'b1, 1'b0, {(SW-1){1'b1}}};
        else if (v < ST_MIN)
            r = {1'b1, 1'b1, {(SW-1){1'b0}}};
        else
            r = {1'b0, v[SW-1:0]};
        return r;
    endfunction

    function automatic logic signed [OPW-1:0] pick(
        input lsi_pkg::src_t  s,
        input logic [1:0]     stg,
        input logic signed [SW-1:0] px, py, pz, qx, qy, qz,
        input logic signed [SW-1:0] kx, ky, kz, rx, ry, rz, t0, t1,
        input logic signed [31:0] sg, rh, bt,
        input logic [30:0]    dt
    );
        logic signed [OPW-1:0] r;
        case (s)
            lsi_pkg::SRC_PX:   r = OPW'(px);
            lsi_pkg::SRC_PY:   r = OPW'(py);
            lsi_pkg::SRC_PZ:   r = OPW'(pz);
            lsi_pkg::SRC_QX:   r = OPW'(qx);
            lsi_pkg::SRC_QY:   r = OPW'(qy);
            lsi_pkg::SRC_QZ:   r = OPW'(qz);
            lsi_pkg::SRC_KX:   r = OPW'(kx);
            lsi_pkg::SRC_KY:   r = OPW'(ky);
            lsi_pkg::SRC_KZ:   r = OPW'(kz);
            lsi_pkg::SRC_RX:   r = OPW'(rx);
            lsi_pkg::SRC_RY:   r = OPW'(ry);
            lsi_pkg::SRC_RZ:   r = OPW'(rz);
            lsi_pkg::SRC_T0:   r = OPW'(t0);
            lsi_pkg::SRC_T1:   r = OPW'(t1);
            lsi_pkg::SRC_SIG:  r = OPW'(sg);
            lsi_pkg::SRC_RHO:  r = OPW'(rh);
            lsi_pkg::SRC_BETA: r = OPW'(bt);
            lsi_pkg::SRC_DT:   r = $signed(OPW'(dt));
            lsi_pkg::SRC_CS:   r = (stg == 2'd0 || stg == 2'd3) ? C6 : C3;
            default:           r = '0;
        endcase
        return r;
    endfunction

    assign u   = lsi_pkg::uop_rom(pc_reg);
    assign opa = pick(u.a, stage_reg, px_reg, py_reg, pz_reg, qx_reg, qy_reg, qz_reg,
                      kx_reg, ky_reg, kz_reg, rx_reg, ry_reg, rz_reg, t0_reg, t1_reg,
                      sigma_reg, rho_reg, beta_reg, dt_reg);
    assign opb = pick(u.b, stage_reg, px_reg, py_reg, pz_reg, qx_reg, qy_reg, qz_reg,
                      kx_reg, ky_reg, kz_reg, rx_reg, ry_reg, rz_reg, t0_reg, t1_reg,
                      sigma_reg, rho_reg, beta_reg, dt_reg);

    // Single adder: the second operand is halved for the early Runge-Kutta stages.
    always_comb
    begin
        alu_a = (OPW+1)'(opa);
        if (u.op == lsi_pkg::OP_ADDS && stage_reg < 2'd2)
            alu_b = (OPW+1)'(opa - opa) + ((OPW+1)'(opb) >>> 1);
        else
            alu_b = (OPW+1)'(opb);
        alu_sum = (u.op == lsi_pkg::OP_SUB) ? alu_a - alu_b : alu_a + alu_b;
        alu_res = sat_sw(alu_sum);
    end

    assign ld_x = sat_sw((OPW+1)'($signed(s_axis_tdata[31:0])));
    assign ld_y = sat_sw((OPW+1)'($signed(s_axis_tdata[63:32])));
    assign ld_z = sat_sw((OPW+1)'($signed(s_axis_tdata[95:64])));

    lsi_serial_mul #(
        .OPW  (OPW),
        .SW   (SW),
        .FRAC (FRAC_BITS)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op_a    (opa),
        .op_b    (opb),
        .done    (mul_done),
        .product (mul_prod),
        .clip    (mul_clip)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_wr        = psel & penable & pwrite;

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        stage_next = stage_reg;
        clip_next  = clip_reg;
        sigma_next = sigma_reg;
        rho_next   = rho_reg;
        beta_next  = beta_reg;
        dt_next    = dt_reg;
        mode_next  = mode_reg;
        px_next = px_reg; py_next = py_reg; pz_next = pz_reg;
        qx_next = qx_reg; qy_next = qy_reg; qz_next = qz_reg;
        kx_next = kx_reg; ky_next = ky_reg; kz_next = kz_reg;
        rx_next = rx_reg; ry_next = ry_reg; rz_next = rz_reg;
        t0_next = t0_reg; t1_next = t1_reg;
        out_valid_next = out_valid_reg & ~m_axis_tready;
        ox_next   = ox_reg;
        oy_next   = oy_reg;
        oz_next   = oz_reg;
        osat_next = osat_reg;
        mul_start = 1'b0;
        wr_en     = 1'b0;
        wr_val    = alu_res[SW-1:0];
        wr_clip   = alu_res[SW];
        adv       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if (s_axis_tuser[0])
                    begin
                        px_next    = ld_x[SW-1:0];
                        py_next    = ld_y[SW-1:0];
                        pz_next    = ld_z[SW-1:0];
                        clip_next  = ld_x[SW] | ld_y[SW] | ld_z[SW];
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        qx_next = px_reg; qy_next = py_reg; qz_next = pz_reg;
                        rx_next = '0; ry_next = '0; rz_next = '0;
                        pc_next    = '0;
                        stage_next = '0;
                        clip_next  = 1'b0;
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_EXEC:
            begin
                if (u.op == lsi_pkg::OP_MUL)
                begin
                    mul_start  = 1'b1;
                    state_next = ST_MWAIT;
                end
                else
                begin
                    wr_en = 1'b1;
                    adv   = 1'b1;
                end
            end
            ST_MWAIT:
            begin
                if (mul_done)
                begin
                    wr_en      = 1'b1;
                    wr_val     = mul_prod;
                    wr_clip    = mul_clip;
                    adv        = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    ox_next        = 32'(px_reg);
                    oy_next        = 32'(py_reg);
                    oz_next        = 32'(pz_reg);
                    osat_next      = clip_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (wr_en)
        begin
            clip_next = clip_reg | wr_clip;
            case (u.d)
                lsi_pkg::SRC_PX: px_next = wr_val;
                lsi_pkg::SRC_PY: py_next = wr_val;
                lsi_pkg::SRC_PZ: pz_next = wr_val;
                lsi_pkg::SRC_QX: qx_next = wr_val;
                lsi_pkg::SRC_QY: qy_next = wr_val;
                lsi_pkg::SRC_QZ: qz_next = wr_val;
                lsi_pkg::SRC_KX: kx_next = wr_val;
                lsi_pkg::SRC_KY: ky_next = wr_val;
                lsi_pkg::SRC_KZ: kz_next = wr_val;
                lsi_pkg::SRC_RX: rx_next = wr_val;
                lsi_pkg::SRC_RY: ry_next = wr_val;
                lsi_pkg::SRC_RZ: rz_next = wr_val;
                lsi_pkg::SRC_T0: t0_next = wr_val;
                lsi_pkg::SRC_T1: t1_next = wr_val;
                default:         t1_next = t1_reg;
            endcase
        end

        // Program flow: derivative, then Euler update, or Runge-Kutta stages then final sum.
        if (adv)
        begin
            if (pc_reg == lsi_pkg::PC_DERIV_END)
                pc_next = mode_reg ? lsi_pkg::PC_RK : lsi_pkg::PC_EUL;
            else if (pc_reg == lsi_pkg::PC_EUL_END || pc_reg == lsi_pkg::PC_FIN_END)
                state_next = ST_DONE;
            else if (pc_reg == lsi_pkg::PC_RK_END)
            begin
                if (stage_reg == 2'd3)
                    pc_next = lsi_pkg::PC_FIN;
                else
                begin
                    stage_next = stage_reg + 2'd1;
                    pc_next    = '0;
                end
            end
            else
                pc_next = pc_reg + 5'd1;
        end

        if (cfg_wr)
        begin
            case (lsi_pkg::reg_idx_t'(paddr[4:2]))
                lsi_pkg::REG_SIGMA: sigma_next = pwdata;
                lsi_pkg::REG_RHO:   rho_next   = pwdata;
                lsi_pkg::REG_BETA:  beta_next  = pwdata;
                lsi_pkg::REG_DT:    dt_next    = pwdata[30:0];
                lsi_pkg::REG_MODE:  mode_next  = pwdata[0];
                default:            mode_next  = mode_reg;
            endcase
        end
    end

    always_comb
    begin
        case (lsi_pkg::reg_idx_t'(paddr[4:2]))
            lsi_pkg::REG_SIGMA: prdata = sigma_reg;
            lsi_pkg::REG_RHO:   prdata = rho_reg;
            lsi_pkg::REG_BETA:  prdata = beta_reg;
            lsi_pkg::REG_DT:    prdata = {1'b0, dt_reg};
            lsi_pkg::REG_MODE:  prdata = {31'd0, mode_reg};
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            stage_reg     <= '0;
            clip_reg      <= 1'b0;
            sigma_reg     <= SIGMA_RST;
            rho_reg       <= RHO_RST;
            beta_reg      <= BETA_RST;
            dt_reg        <= DT_RST;
            mode_reg      <= 1'b0;
            px_reg        <= PX_RST;
            py_reg        <= '0;
            pz_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            stage_reg     <= stage_next;
            clip_reg      <= clip_next;
            sigma_reg     <= sigma_next;
            rho_reg       <= rho_next;
            beta_reg      <= beta_next;
            dt_reg        <= dt_next;
            mode_reg      <= mode_next;
            px_reg        <= px_next;
            py_reg        <= py_next;
            pz_reg        <= pz_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qx_reg <= qx_next; qy_reg <= qy_next; qz_reg <= qz_next;
        kx_reg <= kx_next; ky_reg <= ky_next; kz_reg <= kz_next;
        rx_reg <= rx_next; ry_reg <= ry_next; rz_reg <= rz_next;
        t0_reg <= t0_next; t1_reg <= t1_next;
        ox_reg <= ox_next; oy_reg <= oy_next; oz_reg <= oz_next;
        osat_reg <= osat_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {oz_reg, oy_reg, ox_reg};
    assign m_axis_tuser  = osat_reg;
    assign pready        = 1'b1;

endmodule

[hdl/lsi_serial_mul.sv]
// Bit-serial fixed-point multiplier with floor rescale and saturation.
module lsi_serial_mul #(
    parameter int OPW  = 32,
    parameter int SW   = 32,
    parameter int FRAC = 22
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic signed [OPW-1:0] op_a,
    input  logic signed [OPW-1:0] op_b,
    output logic                  done,
    output logic signed [SW-1:0]  product,
    output logic                  clip
);

    localparam int CW = (OPW > 1) ? $clog2(OPW) : 1;
    localparam logic signed [2*OPW-1:0] P_MAX =
        $signed({{(2*OPW-SW+1){1'b0}}, {(SW-1){1'b1}}});
    localparam logic signed [2*OPW-1:0] P_MIN =
        $signed({{(2*OPW-SW+1){1'b1}}, {(SW-1){1'b0}}});

    logic                  busy_reg, busy_next;
    logic                  fin_reg, fin_next;
    logic                  done_reg, done_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [OPW-1:0]        mag_a_reg, mag_a_next;
    logic [OPW:0]          acc_reg, acc_next;
    logic [OPW-1:0]        lo_reg, lo_next;
    logic                  neg_reg, neg_next;
    logic signed [SW-1:0]  prod_reg, prod_next;
    logic                  clip_reg, clip_next;

    logic [OPW:0]            sum;
    logic [2*OPW-1:0]        full;
    logic signed [2*OPW-1:0] sgn;
    logic signed [2*OPW-1:0] shifted;

    always_comb
    begin
        busy_next  = busy_reg;
        fin_next   = 1'b0;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        mag_a_next = mag_a_reg;
        acc_next   = acc_reg;
        lo_next    = lo_reg;
        neg_next   = neg_reg;
        prod_next  = prod_reg;
        clip_next  = clip_reg;

        sum     = acc_reg + (lo_reg[0] ? {1'b0, mag_a_reg} : '0);
        full    = {acc_reg[OPW-1:0], lo_reg};
        sgn     = neg_reg ? -$signed(full) : $signed(full);
        shifted = sgn >>> FRAC;

        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            acc_next   = '0;
            mag_a_next = op_a[OPW-1] ? OPW'(-op_a) : OPW'(op_a);
            lo_next    = op_b[OPW-1] ? OPW'(-op_b) : OPW'(op_b);
            neg_next   = op_a[OPW-1] ^ op_b[OPW-1];
        end
        else if (busy_reg)
        begin
            acc_next = {1'b0, sum[OPW:1]};
            lo_next  = {sum[0], lo_reg[OPW-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(OPW - 1))
            begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end

        if (fin_reg)
        begin
            done_next = 1'b1;
            if (shifted > P_MAX)
            begin
                prod_next = $signed({1'b0, {(SW-1){1'b1}}});
                clip_next = 1'b1;
            end
            else if (shifted < P_MIN)
            begin
                prod_next = $signed({1'b1, {(SW-1){1'b0}}});
                clip_next = 1'b1;
            end
            else
            begin
                prod_next = shifted[SW-1:0];
                clip_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_a_reg <= mag_a_next;
        acc_reg   <= acc_next;
        lo_reg    <= lo_next;
        neg_reg   <= neg_next;
        prod_reg  <= prod_next;
        clip_reg  <= clip_next;
    end

    assign done    = done_reg;
    assign product = prod_reg;
    assign clip    = clip_reg;

endmodule

[hdl/lsi_checker.sv]
// Port-level checker for the Lorenz integrator, bound to the top level.
`include "lorenz_system_integrator_top_assert.svh"

module lsi_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [0:0] s_axis_tuser,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready
);

    // A stalled result is never withdrawn.
    `LSI_ASSERT_NEXT(a_out_held, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    // Requests are handled one at a time: no request is taken on the cycle after one.
    `LSI_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // A load into an empty output register is checked to show its result on m_axis_tvalid.
    `LSI_ASSERT_NOW(a_load_latency,
        s_axis_tvalid && s_axis_tready && s_axis_tuser[0] && !m_axis_tvalid,
        ##2 m_axis_tvalid)

endmodule

bind lorenz_system_integrator_top lsi_checker u_lsi_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);
